// ===== design/glob_wildcard_matcher_top_assert.svh =====
// Assertion macros for the glob wildcard matcher checker.
// Depends on nothing; included by the checker file.
`ifndef GLOB_WILDCARD_MATCHER_TOP_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define GWM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define GWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/gwm_pkg.sv =====
// Shared types, character codes and helpers for the glob wildcard matcher.
// No dependencies; used by gwm_core and glob_wildcard_matcher_top.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 32;

   // Special pattern characters
   localparam logic [7:0] CH_ANCHOR = 8'h5E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_ANY    = 8'h3F;

   // Request action codes
   localparam logic ACT_PATTERN = 1'b0;
   localparam logic ACT_TEXT    = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] char_byte;
      logic       last;
   } gwm_req_type;

   typedef struct packed {
      logic valid;
      logic matched;
      logic pattern_error;
   } gwm_rsp_type;

   // Fold ASCII upper case to lower case when enabled
   function automatic logic [7:0] fold_char(input logic en, input logic [7:0] c);
      if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
         return c + 8'd32;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/gwm_core.sv =====
// Pattern store and bit-parallel live-position matcher for one request per step.
// Depends on gwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwm_core #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire gwm_pkg::gwm_req_type req,
   input  wire logic                fold_case,
   output gwm_pkg::gwm_rsp_type     rsp
);
   import gwm_pkg::*;

   localparam int CW    = $clog2(MAX_PATTERN + 1);
   localparam int IW    = $clog2(MAX_PATTERN);
   localparam int NP    = MAX_PATTERN + 1;
   localparam int NSTEP = $clog2(NP);

   // Extend live positions across runs of stars (log-depth prefix)
   function automatic logic [NP-1:0] close_stars(input logic [NP-1:0] set,
                                                 input logic [NP-1:0] star);
      logic [NP-1:0] g;
      logic [NP-1:0] q;
      g = set;
      q = star;
      for (int s = 0; s < NSTEP; s++) begin
         g = g | ((g & q) << (1 << s));
         q = q & (q >> (1 << s));
      end
      return g;
   endfunction

   logic [7:0]    store_ff [MAX_PATTERN];
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          sealed_ff, sealed_in;
   logic [NP-1:0] live_ff, live_in;
   logic          at_start_ff, at_start_in;
   logic          af_ff, af_in;

   logic          store_we;
   logic [IW-1:0] store_addr;
   logic [CW-1:0] base_count;

   logic          anchored;
   logic [CW-1:0] len;
   logic [NP-1:0] star_m, adv_m;
   logic [NP-1:0] cur_live, step_live, next_live;
   logic          af_cur;
   logic          err;

   // Drop a leading anchor and measure the remaining pattern
   assign anchored = (count_ff != '0) && (store_ff[0] == CH_ANCHOR);
   assign len      = count_ff - CW'(anchored);

   // Classify each pattern position against the incoming byte
   assign star_m[MAX_PATTERN] = 1'b0;
   assign adv_m[MAX_PATTERN]  = 1'b0;
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
      logic [7:0] eff;
      logic       in_pat;
      logic       is_star;
      logic       is_any;
      logic       is_lit;
      if (i + 1 < MAX_PATTERN) begin : g_shift
         assign eff = anchored ? store_ff[i+1] : store_ff[i];
      end else begin : g_edge
         assign eff = anchored ? 8'h00 : store_ff[i];
      end
      assign in_pat  = CW'(i) < len;
      assign is_star = eff == CH_STAR;
      assign is_any  = eff == CH_ANY;
      assign is_lit  = fold_char(fold_case, eff) == fold_char(fold_case, req.char_byte);
      assign star_m[i] = in_pat && is_star;
      assign adv_m[i]  = in_pat && !is_star && (is_any || is_lit);
   end

   // Advance the live set by one text byte
   assign cur_live  = at_start_ff ? close_stars(NP'(1), star_m) : live_ff;
   assign step_live = (cur_live & star_m) | ((cur_live & adv_m) << 1);
   assign next_live = close_stars(step_live, star_m);

   assign af_cur = at_start_ff
      ? (anchored && ((count_ff < CW'(2)) || (store_ff[1] != req.char_byte)))
      : af_ff;

   // Result for the last text byte
   assign err               = (count_ff == '0) || ovf_ff;
   assign rsp.valid         = (req.action == ACT_TEXT) && req.last;
   assign rsp.pattern_error = err;
   assign rsp.matched       = !err && !af_cur && next_live[len];

   // Next state
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      sealed_in   = sealed_ff;
      live_in     = live_ff;
      at_start_in = at_start_ff;
      af_in       = af_ff;
      store_we    = 1'b0;
      base_count  = sealed_ff ? '0 : count_ff;
      store_addr  = base_count[IW-1:0];
      if (step_en) begin
         if (req.action == ACT_PATTERN) begin
            count_in  = base_count;
            ovf_in    = sealed_ff ? 1'b0 : ovf_ff;
            sealed_in = req.last;
            if (base_count < CW'(MAX_PATTERN)) begin
               store_we = 1'b1;
               count_in = base_count + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            at_start_in = 1'b1;
            af_in       = 1'b0;
         end else begin
            sealed_in = 1'b1;
            live_in   = next_live;
            if (req.last) begin
               at_start_in = 1'b1;
               af_in       = 1'b0;
            end else begin
               at_start_in = 1'b0;
               af_in       = af_cur;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         sealed_ff   <= 1'b0;
         live_ff     <= NP'(1);
         at_start_ff <= 1'b1;
         af_ff       <= 1'b0;
      end else begin
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         sealed_ff   <= sealed_in;
         live_ff     <= live_in;
         at_start_ff <= at_start_in;
         af_ff       <= af_in;
      end
   end

   // Pattern bytes, written in load order
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_addr] <= req.char_byte;
      end
   end

endmodule

`default_nettype wire

// ===== design/glob_wildcard_matcher_top.sv =====
// Top level of the glob wildcard matcher: request register, response register, csr.
// Depends on gwm_pkg and gwm_core.
//
//  channel | ports                                 | handshake
//  --------+---------------------------------------+-------------------
//  request | req_action, req_char_byte, req_last   | req_valid/req_ready
//  response| rsp_matched, rsp_pattern_error        | rsp_valid/rsp_ready
//  csr     | csr_wr_data (fold_case)               | csr_wr_en, no wait
//
// One request per cycle while req_ready is high, the rate of the live-position update
// in gwm_core; a response passes the request register, then the response register.
// Reset clears the pattern count, flags and live set; no clearing pass.
// A last text byte waits in the request register while the response register is held;
// req_ready stays low until it moves, and nothing else ever stalls the request side.
`timescale 1ns / 1ps
`default_nettype none

module glob_wildcard_matcher_top #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic       req_action,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_last,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_matched,
   output      logic       rsp_pattern_error,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);
   import gwm_pkg::*;

   logic        in_vld_ff, in_vld_in;
   gwm_req_type in_req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_matched_ff;
   logic        rsp_error_ff;
   logic        fold_case_ff;
   logic        step_en;
   gwm_rsp_type core_rsp;

   gwm_core #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req      (in_req_ff),
      .fold_case(fold_case_ff),
      .rsp      (core_rsp)
   );

   // Advance unless a response is due and the response register is held
   assign step_en   = in_vld_ff && (!core_rsp.valid || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step_en;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step_en && core_rsp.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Handshake and csr state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fold_case_ff <= 1'b0;
      end else begin
         in_vld_ff    <= in_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fold_case_ff <= csr_wr_data;
         end
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff.action    <= req_action;
         in_req_ff.char_byte <= req_char_byte;
         in_req_ff.last      <= req_last;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (step_en && core_rsp.valid) begin
         rsp_matched_ff <= core_rsp.matched;
         rsp_error_ff   <= core_rsp.pattern_error;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_pattern_error = rsp_error_ff;

endmodule

`default_nettype wire

// ===== design/gwm_checker.sv =====
// Port-level assertions for glob_wildcard_matcher_top, attached by bind.
// Depends on glob_wildcard_matcher_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "glob_wildcard_matcher_top_assert.svh"

module gwm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_action,
   input wire logic [7:0] req_char_byte,
   input wire logic       req_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_matched,
   input wire logic       rsp_pattern_error
);

   // Hold a stalled request
   `GWM_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
      req_valid && $stable(req_action) && $stable(req_char_byte) && $stable(req_last),
      "request changed while stalled")

   // Hold a stalled response
   `GWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_matched) && $stable(rsp_pattern_error),
      "response changed while stalled")

   // A pattern error never reports a match
   `GWM_ASSERT_IMP(a_err_no_match, clock, reset, rsp_valid && rsp_pattern_error,
      !rsp_matched, "match reported with pattern error")

   // Requests stall only behind a held response
   `GWM_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready,
      "request stalled without held response")

   // Reset drops any pending response
   `GWM_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid,
      "response valid after reset")

endmodule

bind glob_wildcard_matcher_top gwm_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for glob_wildcard_matcher_top: a directed stimulus table, then random
// pattern/text sequences under four idling modes, each verdict checked against a typed value or a glob predictor.
// Depends on gwm_pkg and the matcher RTL only.
`timescale 1ns / 1ps

module tb_top;
   import gwm_pkg::*;

   localparam int MAXP          = MAX_PATTERN_DEFAULT;
   localparam int PHASE_REQS    = 425;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic matched;
      logic pattern_error;
   } verdict_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         fold;
      logic         act;
      logic [7:0]   chr;
      logic         lst;
      logic         typed;
      verdict_type  want;
   } stim_row_type;

   // Directed rows; typed verdicts only where they are obvious, the rest go to the predictor
   localparam int N_DIRECTED = 25;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // text before any pattern: empty pattern error
      '{ROW_REQ, 1'b0, ACT_TEXT,    "a",   1'b1, 1'b1, '{1'b0, 1'b1}},
      // lone star matches anything, byte extremes in the text
      '{ROW_REQ, 1'b0, ACT_PATTERN, "*",   1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    8'h00, 1'b1, 1'b1, '{1'b1, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    8'hFF, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    8'h80, 1'b1, 1'b1, '{1'b1, 1'b0}},
      // lone anchor never matches, no error
      '{ROW_REQ, 1'b0, ACT_PATTERN, "^",   1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "^",   1'b1, 1'b1, '{1'b0, 1'b0}},
      // anchored pattern with any-char
      '{ROW_REQ, 1'b0, ACT_PATTERN, "^",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_PATTERN, "A",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_PATTERN, "?",   1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "A",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "z",   1'b1, 1'b0, '{1'b0, 1'b0}},
      // case folding on: anchor check still exact
      '{ROW_CSR, 1'b1, ACT_PATTERN, 8'h00, 1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "a",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "Z",   1'b1, 1'b1, '{1'b0, 1'b0}},
      // unterminated pattern sealed by the first text byte
      '{ROW_REQ, 1'b0, ACT_PATTERN, "H",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_PATTERN, "*",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "h",   1'b1, 1'b0, '{1'b0, 1'b0}},
      // pattern byte in the middle of a text abandons it
      '{ROW_REQ, 1'b0, ACT_PATTERN, "x",   1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "x",   1'b0, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_PATTERN, "y",   1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    "Y",   1'b1, 1'b0, '{1'b0, 1'b0}},
      // all-ones pattern byte
      '{ROW_REQ, 1'b0, ACT_PATTERN, 8'hFF, 1'b1, 1'b0, '{1'b0, 1'b0}},
      '{ROW_REQ, 1'b0, ACT_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0}},
      '{ROW_CSR, 1'b0, ACT_PATTERN, 8'h00, 1'b0, 1'b0, '{1'b0, 1'b0}}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   logic [7:0] req_char_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_matched;
   logic       rsp_pattern_error;
   logic       csr_wr_en;
   logic       csr_wr_data;

   // Predictor state
   logic            fold_en;
   logic [7:0]      pat_mem [MAXP];
   int unsigned     pat_len;
   bit              pat_ovf;
   bit              pat_sealed;
   bit              text_start;
   bit              anchor_bad;
   bit   [MAXP:0]   live;

   verdict_type     verdict_q [$];
   logic [7:0]      cur_pat [$];
   logic [7:0]      cur_txt [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int req_count      = 0;
   int verdicts_seen  = 0;
   int hits_seen      = 0;
   int errs_seen      = 0;
   int mismatch_cnt   = 0;

   glob_wildcard_matcher_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_char_byte    (req_char_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_matched      (rsp_matched),
      .rsp_pattern_error(rsp_pattern_error),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      if (fold_en && c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   // Let every live star also enable the position after it
   function automatic bit [MAXP:0] star_closure(input bit [MAXP:0] s, input int unsigned off,
                                                input int unsigned len);
      bit [MAXP:0] r;
      r = s;
      for (int i = 0; i < int'(len); i++) begin
         if (r[i] && pat_mem[off + i] == CH_STAR) begin
            r[i + 1] = 1'b1;
         end
      end
      return r;
   endfunction

   // Advance the glob state by one request; report a verdict on a last text byte
   function automatic void glob_predict(input logic act, input logic [7:0] c, input logic lst,
                                        output bit has_verdict, output verdict_type v);
      int unsigned off;
      int unsigned len;
      bit [MAXP:0] nxt;
      logic [7:0]  p;
      bit          err;
      has_verdict = 1'b0;
      v = '0;
      if (act == ACT_PATTERN) begin
         if (pat_sealed) begin
            pat_len    = 0;
            pat_ovf    = 1'b0;
            pat_sealed = 1'b0;
         end
         if (pat_len < MAXP) begin
            pat_mem[pat_len] = c;
            pat_len++;
         end else begin
            pat_ovf = 1'b1;
         end
         if (lst) begin
            pat_sealed = 1'b1;
         end
         text_start = 1'b1;
         anchor_bad = 1'b0;
         return;
      end
      pat_sealed = 1'b1;
      off = (pat_len > 0 && pat_mem[0] == CH_ANCHOR) ? 1 : 0;
      len = pat_len - off;
      if (text_start) begin
         live    = '0;
         live[0] = 1'b1;
         live    = star_closure(live, off, len);
         anchor_bad = (off == 1) && (pat_len < 2 || pat_mem[1] != c);
         text_start = 1'b0;
      end
      nxt = '0;
      for (int i = 0; i < int'(len); i++) begin
         p = pat_mem[off + i];
         if (live[i]) begin
            if (p == CH_STAR) begin
               nxt[i] = 1'b1;
            end else if (p == CH_ANY || lower_byte(p) == lower_byte(c)) begin
               nxt[i + 1] = 1'b1;
            end
         end
      end
      live = star_closure(nxt, off, len);
      if (lst) begin
         err = (pat_len == 0) || pat_ovf;
         v.pattern_error = err;
         v.matched = !err && !anchor_bad && live[len];
         has_verdict = 1'b1;
         text_start = 1'b1;
         anchor_bad = 1'b0;
      end
   endfunction

   // Offer one request, idling the sender cycle by cycle first; queue its verdict on acceptance
   task automatic push_req(input logic act, input logic [7:0] c, input logic lst,
                           input bit typed, input verdict_type typed_v);
      bit          has_v;
      verdict_type pv;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_action    = act;
      req_char_byte = c;
      req_last      = lst;
      do @(posedge clock); while (!req_ready);
      glob_predict(act, c, lst, has_v, pv);
      if (has_v) begin
         verdict_q.push_back(typed ? typed_v : pv);
      end
      req_count++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every verdict is in and the pipeline is empty
   task automatic settle();
      req_valid = 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_fold(input logic v);
      csr_wr_data = v;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      fold_en     = v;
   endtask

   function automatic logic [7:0] glob_char();
      case ($urandom_range(11))
         0, 1, 2: return "a";
         3:       return "b";
         4:       return "A";
         5:       return "B";
         6, 7:    return CH_STAR;
         8, 9:    return CH_ANY;
         10:      return CH_ANCHOR;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] text_char();
      case ($urandom_range(9))
         0, 1, 2: return "a";
         3:       return "b";
         4:       return "A";
         5:       return "B";
         6:       return CH_STAR;
         7:       return CH_ANCHOR;
         default: return 8'($urandom);
      endcase
   endfunction

   // Build a text, mostly derived from the current pattern so that matches are common
   task automatic build_text();
      logic [7:0] c;
      cur_txt.delete();
      if ($urandom_range(9) < 6) begin
         foreach (cur_pat[i]) begin
            c = cur_pat[i];
            if (i == 0 && c == CH_ANCHOR) continue;
            if (c == CH_STAR) begin
               repeat ($urandom_range(3)) cur_txt.push_back(text_char());
            end else if (c == CH_ANY) begin
               cur_txt.push_back(8'($urandom));
            end else begin
               if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(4) == 0) begin
                  c = c ^ 8'h20;
               end
               cur_txt.push_back(c);
            end
         end
         if (cur_txt.size() > 0 && $urandom_range(9) == 0) begin
            cur_txt[$urandom_range(cur_txt.size() - 1)] = text_char();
         end
      end else begin
         repeat ($urandom_range(1, 8)) cur_txt.push_back(text_char());
      end
      if (cur_txt.size() == 0) begin
         cur_txt.push_back(text_char());
      end
   endtask

   // One pattern followed by a few texts; now and then leave the pattern open or cut a text
   task automatic run_sequence();
      int  plen;
      int  n_txt;
      bit  open_pat;
      bit  cut;
      int  stop;
      cur_pat.delete();
      plen = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
      if ($urandom_range(6) == 0) begin
         cur_pat.push_back(CH_ANCHOR);
      end
      while (cur_pat.size() < plen) cur_pat.push_back(glob_char());
      open_pat = ($urandom_range(9) == 0);
      foreach (cur_pat[i]) begin
         push_req(ACT_PATTERN, cur_pat[i], (i == cur_pat.size() - 1) && !open_pat, 1'b0, '0);
      end
      n_txt = $urandom_range(1, 4);
      for (int t = 0; t < n_txt; t++) begin
         build_text();
         cut  = (t == n_txt - 1) && ($urandom_range(11) == 0);
         stop = cut ? $urandom_range(cur_txt.size()) : cur_txt.size();
         for (int k = 0; k < stop; k++) begin
            push_req(ACT_TEXT, cur_txt[k], !cut && (k == cur_txt.size() - 1), 1'b0, '0);
         end
      end
   endtask

   task automatic log_mismatch(input string what, input verdict_type want,
                               input verdict_type got);
      if (mismatch_cnt < REPORT_LIMIT) begin
         $display("tb_top: %s at %0t: expected matched=%0b error=%0b, got matched=%0b error=%0b",
                  what, $time, want.matched, want.pattern_error, got.matched, got.pattern_error);
      end
      mismatch_cnt++;
   endtask

   // Check every accepted verdict against the oldest expectation
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_matched, rsp_pattern_error};
         verdicts_seen++;
         if (got.matched) hits_seen++;
         if (got.pattern_error) errs_seen++;
         if (verdict_q.size() == 0) begin
            log_mismatch("unexpected verdict", '0, got);
         end else begin
            want = verdict_q.pop_front();
            if (got.matched !== want.matched) begin
               log_mismatch("matched mismatch", want, got);
            end
            if (got.pattern_error !== want.pattern_error) begin
               log_mismatch("pattern_error mismatch", want, got);
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #6_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      stim_row_type row;
      int           phase_end;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_action    = ACT_PATTERN;
      req_char_byte = 8'h00;
      req_last      = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      fold_en       = 1'b0;
      pat_len       = 0;
      pat_ovf       = 1'b0;
      pat_sealed    = 1'b0;
      text_start    = 1'b1;
      anchor_bad    = 1'b0;
      live          = '0;
      live[0]       = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            settle();
            write_fold(row.fold);
         end else begin
            push_req(row.act, row.chr, row.lst, row.typed, row.want);
         end
      end

      // Random sequences under each idling mode, case folding alternating
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         settle();
         write_fold((ph % 2) == 0);
         phase_end = req_count + PHASE_REQS;
         while (req_count < phase_end) run_sequence();
      end
      settle();

      $display("tb_top: %0d requests sent under four idling modes, both case settings",
               req_count);
      $display("tb_top: %0d verdicts checked (%0d matches, %0d pattern errors), %0d mismatches",
               verdicts_seen, hits_seen, errs_seen, mismatch_cnt);
      if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
